>>> hw/rtl/bcmp_pkg.sv
// ----------------------------------------------------------------------------
// bcmp_pkg: shared types and constants for the binomial mod prime block
// Prime modulus, table depth, queue entry and lookup request types.
// ----------------------------------------------------------------------------
package bcmp_pkg;

  localparam int unsigned MaxN      = 4095;
  localparam int unsigned TabDepth  = MaxN + 1;
  localparam int unsigned IdxW      = $clog2(TabDepth);
  localparam int unsigned ValW      = 30;
  localparam int unsigned ExpW      = 30;
  localparam logic [ValW-1:0] ModP  = 30'd1000000007;
  localparam logic [ExpW-1:0] ModExp = 30'd1000000005;

  // Classified query as it travels from the front to the back.
  typedef struct packed {
    logic            valid_args;  // 0 <= k <= n
    logic            overflow;    // valid args but n beyond the table
    logic [IdxW-1:0] n_idx;
    logic [IdxW-1:0] k_idx;
    logic [IdxW-1:0] nk_idx;
  } query_t;

  // Barrett reduction of a 60-bit product: mu = floor(2^60 / p).
  // 2^29 <= p < 2^30, so the quotient estimate is at most 2 low.
  localparam logic [ValW:0] BarrettMu = 31'd1152921496;

endpackage

>>> hw/rtl/bcmp_if.sv
// ----------------------------------------------------------------------------
// bcmp_if: valid/ready channel carrying a generic payload
// One interface type is used for the query and the result channels.
// ----------------------------------------------------------------------------
interface bcmp_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bcmp_modmul.sv
// ----------------------------------------------------------------------------
// bcmp_modmul: pipelined multiply mod p
// Four stages: product, quotient estimate, remainder, final correction.
// Valid rides along; no stall, caller holds spare queue room.
// ----------------------------------------------------------------------------
module bcmp_modmul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [bcmp_pkg::ValW-1:0]  a_i,
  input  logic [bcmp_pkg::ValW-1:0]  b_i,
  output logic                       out_valid_o,
  output logic [bcmp_pkg::ValW-1:0]  res_o
);
  import bcmp_pkg::*;

  // stage 1: full product, < p^2 < 2^60
  logic [2*ValW-1:0] prod_q;
  // stage 2: quotient estimate and low word of the product
  logic [ValW:0]     quo_q;
  logic [31:0]       lo_q;
  // stage 3: remainder in [0, 3p), fits 32 bits
  logic [31:0]       rem_q;
  logic [ValW-1:0]   res_q;
  logic [3:0]        v_q;

  logic [2*ValW+1:0] quo_full;
  logic [2*ValW:0]   qp_full;
  logic [31:0]       rem_d;
  logic [ValW-1:0]   res_d;

  always_comb begin
    // q = ((x >> 29) * mu) >> 31
    quo_full = {31'd0, prod_q[2*ValW-1:ValW-1]} * {31'd0, BarrettMu};
    // remainder below 2^32, so the low word of x - q*p is exact
    qp_full  = {30'd0, quo_q} * {31'd0, ModP};
    rem_d    = lo_q - qp_full[31:0];
    if (rem_q >= {1'b0, ModP, 1'b0}) res_d = ValW'(rem_q - {1'b0, ModP, 1'b0});
    else if (rem_q >= {2'b0, ModP}) res_d = ValW'(rem_q - {2'b0, ModP});
    else res_d = rem_q[ValW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    quo_q  <= quo_full[2*ValW+1:ValW+1];
    lo_q   <= prod_q[31:0];
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  logic unused_w;
  assign unused_w = ^{quo_full[ValW:0], qp_full[2*ValW:32]};
  assign out_valid_o = v_q[3];
  assign res_o       = res_q;
endmodule

>>> hw/rtl/bcmp_front.sv
// ----------------------------------------------------------------------------
// bcmp_front: query classification
// Range checks on n, k and n-k; registered into a short queue.
// ----------------------------------------------------------------------------
module bcmp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  bcmp_if.sink                query_if,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output bcmp_pkg::query_t    q_data_o
);
  import bcmp_pkg::*;

  localparam int unsigned QDepth = 2;

  query_t      fifo_q [QDepth];
  logic [1:0]  cnt_q;
  logic        wr_ptr_q, rd_ptr_q;
  query_t      cls;
  logic signed [32:0] diff;
  logic        push, pop;

  always_comb begin
    diff           = 33'(signed'(query_if.data.n_total)) - 33'(signed'(query_if.data.k_chosen));
    cls.valid_args = !query_if.data.n_total[31] && !query_if.data.k_chosen[31] && !diff[32];
    cls.overflow   = cls.valid_args && (query_if.data.n_total > 32'(MaxN));
    cls.n_idx      = query_if.data.n_total[IdxW-1:0];
    cls.k_idx      = query_if.data.k_chosen[IdxW-1:0];
    cls.nk_idx     = diff[IdxW-1:0];
  end

  assign query_if.ready = en_i && (cnt_q != 2'(QDepth));
  assign push = query_if.valid && query_if.ready;
  assign pop  = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wr_ptr_q <= 1'b0; rd_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cls;
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QDepth))
    else $error("queue count out of range");
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && cls.overflow |-> cls.valid_args) else $error("overflow without valid args");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> wr_ptr_q == rd_ptr_q) else $error("empty queue pointer mismatch");
endmodule

>>> hw/rtl/bcmp_back.sv
// ----------------------------------------------------------------------------
// bcmp_back: table fill sequencer and lookup pipeline
// Fills fact and inv-fact tables after reset with the shared multiplier,
// then runs queries: read, mul, mul, into an output queue.
// ----------------------------------------------------------------------------
module bcmp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                ready_o,   // tables filled
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  bcmp_pkg::query_t    q_data_i,
  bcmp_if.source              result_if
);
  import bcmp_pkg::*;

  typedef enum logic [2:0] {
    S_FACT, S_FWAIT, S_POW, S_PWAIT, S_RUN
  } state_e;

  logic [ValW-1:0] fact_mem [TabDepth];
  logic [ValW-1:0] inv_mem  [TabDepth];

  state_e          state_q;
  logic [IdxW:0]   idx_q;      // fill counter
  logic [ValW-1:0] run_q;      // running factorial
  logic [ValW-1:0] acc_q;      // pow accumulator
  logic [ValW-1:0] sq_q;
  logic [ExpW-1:0] e_q;
  logic            phase_q;    // pow: 0 acc mul, 1 square mul

  // shared multiplier
  logic            mv;
  logic [ValW-1:0] ma, mb, mr;
  logic            mo;
  bcmp_modmul u_mul (.clk_i, .rst_ni, .in_valid_i(mv), .a_i(ma), .b_i(mb),
                     .out_valid_o(mo), .res_o(mr));

  // second multiplier for query path
  logic            m2v, m2o;
  logic [ValW-1:0] m2a, m2b, m2r;
  bcmp_modmul u_mul2 (.clk_i, .rst_ni, .in_valid_i(m2v), .a_i(m2a), .b_i(m2b),
                      .out_valid_o(m2o), .res_o(m2r));

  // query pipeline
  localparam int unsigned OutDepth = 16;
  localparam int unsigned OutW = $clog2(OutDepth);
  localparam int unsigned Lat = 11;   // table read, mul, register, mul, queue write
  logic [OutW:0]  credit_q;           // results in flight or buffered
  logic           take;
  logic           rd_v_q, rd_ok_q, rd_ov_q;
  logic [ValW-1:0] rf_q, rn_q, rk_q;
  logic [ValW-1:0] rk_d1_q [4];
  logic [4:0]     ok_sh_q, ov_sh_q;   // aligned with multiplier 1
  logic [ValW-1:0] p1_q;
  logic           p1_v_q, p1_ok_q, p1_ov_q;
  logic [3:0]     ok2_q, ov2_q;
  logic [ValW-1:0] m2b_q;

  assign ready_o   = (state_q == S_RUN);
  assign q_ready_o = ready_o && (credit_q < (OutW+1)'(OutDepth));
  assign take      = q_valid_i && q_ready_o;

  always_comb begin
    mv = 1'b0; ma = run_q; mb = ValW'(idx_q);
    case (state_q)
      S_FACT: begin
        mv = (idx_q != '0); ma = run_q; mb = ValW'(idx_q + 1'b1);
      end
      S_POW: begin
        mv = 1'b1;
        ma = phase_q ? sq_q : acc_q;
        mb = sq_q;
      end
      S_RUN: begin mv = rd_v_q; ma = rf_q; mb = rn_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FACT; idx_q <= '0; run_q <= ValW'(1);
      acc_q <= ValW'(1); sq_q <= '0; e_q <= '0; phase_q <= 1'b0;
    end else begin
      case (state_q)
        S_FACT: begin
          // entry idx gets run = idx!; next run = run * (idx+1)
          if (idx_q == '0) begin
            run_q <= ValW'(1);
            idx_q <= (IdxW+1)'(1);
          end else state_q <= S_FWAIT;
        end
        S_FWAIT: if (mo) begin
          run_q <= mr;
          if (idx_q == (IdxW+1)'(MaxN)) begin
            state_q <= S_POW; idx_q <= '0; sq_q <= ValW'(1);
            acc_q <= ValW'(1); e_q <= ModExp; phase_q <= 1'b0;
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= S_FACT;
          end
        end
        S_POW: state_q <= S_PWAIT;
        S_PWAIT: if (mo) begin
          if (!phase_q) begin
            if (e_q[0]) acc_q <= mr;
            phase_q <= 1'b1; state_q <= S_POW;
          end else begin
            phase_q <= 1'b0;
            if (e_q[ExpW-1:1] == '0) begin
              if (idx_q == (IdxW+1)'(MaxN)) state_q <= S_RUN;
              else begin
                idx_q <= idx_q + 1'b1; state_q <= S_POW;
                sq_q <= fact_mem[idx_q[IdxW-1:0] + 1'b1]; acc_q <= ValW'(1);
                e_q <= ModExp;
              end
            end else begin
              sq_q <= mr; e_q <= e_q >> 1; state_q <= S_POW;
            end
          end
        end
        S_RUN: ;
        default: state_q <= S_FACT;
      endcase
    end
  end

  // fact writes: S_FACT writes run_q at idx; pow start reads fact[idx]
  logic fact_we, inv_we;
  assign fact_we = (state_q == S_FACT);
  assign inv_we  = (state_q == S_PWAIT) && mo && phase_q && (e_q[ExpW-1:1] == '0);

  always_ff @(posedge clk_i) begin
    if (fact_we) fact_mem[idx_q[IdxW-1:0]] <= (idx_q == '0) ? ValW'(1) : run_q;
    if (inv_we)  inv_mem[idx_q[IdxW-1:0]] <= acc_q;
    rf_q <= fact_mem[q_data_i.n_idx];
    rn_q <= inv_mem[q_data_i.nk_idx];
    rk_q <= inv_mem[q_data_i.k_idx];
  end

  // First pow operand: fact[0]=1 since sq_q starts 1 at idx 0. The exponent
  // loop reads sq_q as the base; squaring happens after acc mul each bit.

  // query control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0; ok_sh_q <= '0; ov_sh_q <= '0;
      ok2_q <= '0; ov2_q <= '0;
    end else begin
      rd_v_q  <= take;
      ok_sh_q <= {ok_sh_q[3:0], take && q_data_i.valid_args && !q_data_i.overflow};
      ov_sh_q <= {ov_sh_q[3:0], take && q_data_i.overflow};
      ok2_q   <= {ok2_q[2:0], p1_ok_q};
      ov2_q   <= {ov2_q[2:0], p1_ov_q};
    end
  end

  always_ff @(posedge clk_i) begin
    rk_d1_q[0] <= rk_q;
    for (int i = 1; i < 4; i++) rk_d1_q[i] <= rk_d1_q[i-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0; p1_ok_q <= 1'b0; p1_ov_q <= 1'b0;
    end else begin
      p1_v_q  <= ready_o && mo;
      p1_ok_q <= ok_sh_q[4];
      p1_ov_q <= ov_sh_q[4];
    end
  end
  always_ff @(posedge clk_i) begin
    p1_q  <= mr;
    m2b_q <= rk_d1_q[3];
  end
  assign m2v = p1_v_q;
  assign m2a = p1_q;
  assign m2b = m2b_q;

  // output queue
  typedef struct packed {
    logic [ValW-1:0] value;
    logic            over;
  } res_t;
  res_t            oq_q [OutDepth];
  logic [OutW-1:0] owp_q, orp_q;
  logic [OutW:0]   ocnt_q;
  logic            opush, opop;
  res_t            ores;

  assign opush = m2o;
  assign opop  = result_if.valid && result_if.ready;
  assign ores.value = ok2_q[3] ? m2r : '0;
  assign ores.over  = ov2_q[3];
  assign result_if.valid = (ocnt_q != '0);
  assign result_if.data.binom_value    = oq_q[orp_q].value;
  assign result_if.data.table_overflow = oq_q[orp_q].over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q <= '0; orp_q <= '0; ocnt_q <= '0; credit_q <= '0;
    end else begin
      if (opush) owp_q <= owp_q + 1'b1;
      if (opop)  orp_q <= orp_q + 1'b1;
      ocnt_q   <= ocnt_q + (OutW+1)'(opush) - (OutW+1)'(opop);
      credit_q <= credit_q + (OutW+1)'(take) - (OutW+1)'(opop);
    end
  end
  always_ff @(posedge clk_i) begin
    if (opush) oq_q[owp_q] <= ores;
  end

  logic unused_b;
  assign unused_b = ^{rd_ok_q, rd_ov_q, Lat};
  assign rd_ok_q = 1'b0;
  assign rd_ov_q = 1'b0;

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= credit_q) else $error("buffered results exceed credits");
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> state_q == S_RUN) else $error("query taken during fill");
  a_nopush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opush |-> ocnt_q < (OutW+1)'(OutDepth) || opop) else $error("output queue overrun");
endmodule

>>> hw/rtl/binomial_coefficient_mod_prime_top.sv
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime_top: n choose k mod 1000000007
// Factorial and inverse-factorial tables, filled after reset, feed two
// pipelined modular multipliers; queries are classified up front.
//
//  channel   dir  payload                          handshake
//  query_if  in   n_total[31:0] s, k_chosen[31:0] s valid/ready
//  result_if out  binom_value[29:0], table_overflow  valid/ready
//
// After reset the back fills the tables through the shared multiplier,
// one multiply per factorial entry and 60 multiplies per inverse entry;
// no query is taken until the tables are filled. Afterwards one query
// per cycle while the output queue has credit, through the table read
// and two 4-stage multipliers. A 2-entry queue splits front and back;
// a 16-entry output queue absorbs result stalls.
// ----------------------------------------------------------------------------
module binomial_coefficient_mod_prime_top (
  input  logic clk_i,
  input  logic rst_ni,
  bcmp_if.sink   query_if,
  bcmp_if.source result_if
);
  import bcmp_pkg::*;

  logic   en;
  logic   qv, qr;
  query_t qd;

  bcmp_front u_front (.clk_i, .rst_ni, .en_i(en), .query_if,
                      .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd));
  bcmp_back u_back (.clk_i, .rst_ni, .ready_o(en), .q_valid_i(qv),
                    .q_ready_o(qr), .q_data_i(qd), .result_if);
endmodule
